@@ rtl/bit_sync_beat_deframer_top_assert.svh @@
// Assertion macros for the sync-byte deframer.
// Needs aclk and aresetn in the scope that expands them.
`ifndef BIT_SYNC_BEAT_DEFRAMER_TOP_ASSERT_SVH
`define BIT_SYNC_BEAT_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define BSBD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSBD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bsbd_pkg.sv @@
// Constants and widths for the sync-byte deframer.
// No dependencies.
package bsbd_pkg;
    localparam int BYTES_PER_BEAT  = 16;
    localparam int BEAT_COUNT_BITS = 16;
    localparam int BYTE_CNT_W      = (BYTES_PER_BEAT > 1) ? $clog2(BYTES_PER_BEAT) : 1;
    localparam int CMP_W           = (BEAT_COUNT_BITS > 16) ? BEAT_COUNT_BITS : 16;
    localparam logic [7:0] SYNC_BYTE = 8'hFE;

    typedef logic [BYTE_CNT_W-1:0]      byte_cnt_t;
    typedef logic [BEAT_COUNT_BITS-1:0] beat_cnt_t;
endpackage

@@ rtl/bit_sync_beat_deframer_top.sv @@
// Sync-byte hunting deframer: top level, single module.
// Depends on bsbd_pkg and bit_sync_beat_deframer_top_assert.svh.
//
// Usage:
//   s_ channel: one received byte per request, MSB first in time.
//     s_tuser marks the first byte of a read window, s_tlast the last.
//   m_ channel: one result per byte that completes a payload byte or is a
//     window-last byte (m_tlast), the latter carrying the status in m_tuser[1].
//   cfg channel: writes beats_expected (reset value 1); always ready, write
//     only while the block holds no request.
// Timing: an input register, then the eight bit steps in one combinational
//   pass into the result register. m_tvalid rises once the result of an
//   accepted byte is in the result register; one byte per cycle sustained
//   while m_tready is high.
// Stall: a held result blocks the pass stage; the input register takes one
//   more request only if empty, then s_tready drops until m_tready returns.
// Reset: aresetn clears the hunt state, both stage valids and sets
//   beats_expected to 1.
module bit_sync_beat_deframer_top
    import bsbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] window_first
    input  logic        s_tlast,   // window_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] payload_byte, [23:8] beat_index,
                                   // [27:24] byte_in_beat, [31:28] zero
    output logic [1:0]  m_tuser,   // [0] data_valid, [1] success
    output logic        m_tlast,   // window_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic        in_last_reg;

    logic [15:0] beats_exp_reg;

    logic [7:0]  hunt_reg, hunt_next;
    logic        in_payload_reg, in_payload_next;
    logic [7:0]  partial_reg, partial_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    byte_cnt_t   byte_cnt_reg, byte_cnt_next;
    beat_cnt_t   beats_done_reg, beats_done_next;

    logic        out_vld_reg;
    logic        out_dv_reg, out_dv_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [15:0] out_beat_reg, out_beat_next;
    logic [3:0]  out_pos_reg, out_pos_next;
    logic        out_end_reg;
    logic        out_succ_reg, out_succ_next;

    logic        advance;
    logic        emit;

    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        logic [7:0]  hs;
        logic        inp;
        logic [7:0]  pb;
        logic [2:0]  bc;
        byte_cnt_t   pc;
        beat_cnt_t   bd;
        beat_cnt_t   bd_inc;
        logic        stop;
        logic        stop_inc;
        logic        have;
        logic        bit_v;
        logic [7:0]  g_byte;
        beat_cnt_t   g_beat;
        byte_cnt_t   g_pos;

        if (in_first_reg) begin
            hs = '0; inp = 1'b0; pb = '0; bc = '0; pc = '0; bd = '0;
        end else begin
            hs = hunt_reg; inp = in_payload_reg; pb = partial_reg;
            bc = bit_cnt_reg; pc = byte_cnt_reg; bd = beats_done_reg;
        end
        bd_inc   = bd + 1'b1;
        stop     = CMP_W'(bd) >= CMP_W'(beats_exp_reg);
        stop_inc = CMP_W'(bd_inc) >= CMP_W'(beats_exp_reg);
        have     = 1'b0;
        g_byte   = '0;
        g_beat   = '0;
        g_pos    = '0;

        for (int i = 7; i >= 0; i--) begin
            bit_v = in_byte_reg[i];
            if (!stop) begin
                if (!inp) begin
                    hs = {hs[6:0], bit_v};
                    if (hs == SYNC_BYTE) begin
                        inp = 1'b1; pb = '0; bc = '0; pc = '0;
                    end
                end else begin
                    pb = {pb[6:0], bit_v};
                    if (bc == 3'd7) begin
                        bc     = '0;
                        have   = 1'b1;
                        g_byte = pb;
                        g_beat = bd;
                        g_pos  = pc;
                        if (pc == byte_cnt_t'(BYTES_PER_BEAT - 1)) begin
                            pc   = '0;
                            bd   = bd_inc;
                            stop = stop_inc;
                            inp  = 1'b0;
                            hs   = '0;
                        end else begin
                            pc = pc + 1'b1;
                        end
                    end else begin
                        bc = bc + 1'b1;
                    end
                end
            end
        end

        emit          = have || in_last_reg;
        out_dv_next   = have;
        out_byte_next = g_byte;
        out_beat_next = 16'(g_beat);
        out_pos_next  = 4'(g_pos);
        out_succ_next = in_last_reg && stop;

        if (in_last_reg) begin
            hunt_next = '0; in_payload_next = 1'b0; partial_next = '0;
            bit_cnt_next = '0; byte_cnt_next = '0; beats_done_next = '0;
        end else begin
            hunt_next = hs; in_payload_next = inp; partial_next = pb;
            bit_cnt_next = bc; byte_cnt_next = pc; beats_done_next = bd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            beats_exp_reg  <= 16'd1;
            hunt_reg       <= '0;
            in_payload_reg <= 1'b0;
            partial_reg    <= '0;
            bit_cnt_reg    <= '0;
            byte_cnt_reg   <= '0;
            beats_done_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                beats_exp_reg <= cfg_data;
            end
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg    <= emit;
                hunt_reg       <= hunt_next;
                in_payload_reg <= in_payload_next;
                partial_reg    <= partial_next;
                bit_cnt_reg    <= bit_cnt_next;
                byte_cnt_reg   <= byte_cnt_next;
                beats_done_reg <= beats_done_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        if (advance && emit) begin
            out_dv_reg   <= out_dv_next;
            out_byte_reg <= out_byte_next;
            out_beat_reg <= out_beat_next;
            out_pos_reg  <= out_pos_next;
            out_end_reg  <= in_last_reg;
            out_succ_reg <= out_succ_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000, out_pos_reg, out_beat_reg, out_byte_reg};
    assign m_tuser  = {out_succ_reg, out_dv_reg};
    assign m_tlast  = out_end_reg;

`include "bit_sync_beat_deframer_top_assert.svh"

    `BSBD_ASSERT_IMP(a_nodata_is_status, m_tvalid && !m_tuser[0], m_tlast, "result without data must be a window end")
    `BSBD_ASSERT_IMP(a_nodata_zero, m_tvalid && !m_tuser[0], m_tdata == 32'd0, "fields must be zero without data")
    `BSBD_ASSERT_IMP(a_success_at_end, m_tvalid && m_tuser[1], m_tlast, "success only on window end")
    `BSBD_ASSERT_IMP(a_hunt_bitcnt, !in_payload_reg, bit_cnt_reg == 3'd0, "bit count must be zero while hunting")
    `BSBD_ASSERT_NXT(a_end_clears, advance && in_last_reg, !in_payload_reg && beats_done_reg == '0, "window end must clear search state")

endmodule

@@ sim/tb_bit_sync_beat_deframer_top.sv @@
// Testbench for bit_sync_beat_deframer_top: directed and random read windows
// checked against a bit-level sync hunt predictor held in a scoreboard class.
// Depends on bsbd_pkg and the RTL top level only.
`timescale 1ns / 1ps

import bsbd_pkg::*;

typedef struct {
    logic       data_valid;
    logic [7:0] payload;
    beat_cnt_t  beat_index;
    logic [3:0] byte_pos;
    logic       window_end;
    logic       success;
} deframed_t;

class deframe_scoreboard;
    logic [7:0]  hunt_reg;
    bit          collecting;
    logic [7:0]  partial;
    int          bit_cnt;
    int          byte_cnt;
    beat_cnt_t   beats_done;
    logic [15:0] beats_wanted;
    deframed_t   deframed_q[$];
    int          errors;

    function new();
        clear_hunt();
        beats_wanted = 16'd1;
        errors = 0;
    endfunction

    function void clear_hunt();
        hunt_reg = '0;
        collecting = 1'b0;
        partial = '0;
        bit_cnt = 0;
        byte_cnt = 0;
        beats_done = '0;
    endfunction

    function void set_beats(logic [15:0] v);
        beats_wanted = v;
    endfunction

    function int pending();
        return deframed_q.size();
    endfunction

    function void note_byte(logic [7:0] rx, logic win_first, logic win_last);
        deframed_t r;
        logic b;
        r = '{default: '0};
        if (win_first)
            clear_hunt();
        for (int i = 7; i >= 0; i--) begin
            if (16'(beats_done) >= beats_wanted)
                break;
            b = rx[i];
            if (!collecting) begin
                hunt_reg = {hunt_reg[6:0], b};
                if (hunt_reg == SYNC_BYTE) begin
                    collecting = 1'b1;
                    partial = '0;
                    bit_cnt = 0;
                    byte_cnt = 0;
                end
            end else begin
                partial = {partial[6:0], b};
                if (bit_cnt == 7) begin
                    bit_cnt = 0;
                    r.data_valid = 1'b1;
                    r.payload = partial;
                    r.beat_index = beats_done;
                    r.byte_pos = byte_cnt[3:0];
                    byte_cnt++;
                    if (byte_cnt >= BYTES_PER_BEAT) begin
                        byte_cnt = 0;
                        beats_done = beats_done + 1'b1;
                        collecting = 1'b0;
                        hunt_reg = '0;
                    end
                end else begin
                    bit_cnt++;
                end
            end
        end
        if (!r.data_valid && !win_last)
            return;
        r.window_end = win_last;
        r.success = win_last && (16'(beats_done) >= beats_wanted);
        deframed_q.insert(deframed_q.size(), r);
        if (win_last)
            clear_hunt();
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [31:0] tdata, logic [1:0] tuser, logic tlast);
        deframed_t want;
        if (deframed_q.size() == 0) begin
            $error("result with nothing pending: tdata %h tuser %b tlast %b",
                   tdata, tuser, tlast);
            errors++;
            return;
        end
        want = deframed_q.pop_front();
        cmp_field("data_valid", want.data_valid, tuser[0]);
        cmp_field("payload_byte", want.payload, tdata[7:0]);
        cmp_field("beat_index", want.beat_index, tdata[23:8]);
        cmp_field("byte_in_beat", want.byte_pos, tdata[27:24]);
        cmp_field("tdata pad", 16'd0, tdata[31:28]);
        cmp_field("window_end", want.window_end, tlast);
        cmp_field("success", want.success, tuser[1]);
    endfunction
endclass

module tb_bit_sync_beat_deframer_top;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] rx_byte
    logic        s_tuser = 1'b0;  // [0] window_first
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [7:0] payload, [23:8] beat, [27:24] pos, [31:28] 0
    logic [1:0]  m_tuser;         // [0] data_valid, [1] success
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    deframe_scoreboard deframer = new();
    bit tx_gaps_on = 1'b0;
    bit rx_stall_on = 1'b0;
    int bytes_sent = 0;

    bit_sync_beat_deframer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            deframer.note_byte(s_tdata, s_tuser, s_tlast);
        if (aresetn && cfg_valid && cfg_ready)
            deframer.set_beats(cfg_data);
        if (aresetn && m_tvalid && m_tready)
            deframer.check_result(m_tdata, m_tuser, m_tlast);
    end

    // result side; two long hold-offs let the block fill and stall its input
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = rx_stall_on ? $urandom_range(0, 16) : 0;
            if (taken == 150 || taken == 900)
                stall = 400;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic win_first,
                             input logic win_last);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= win_first;
        s_tlast  <= win_last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (deframer.pending() != 0)
            @(posedge aclk);
    endtask

    // register write only once every pending request has drained
    task automatic write_beats(input logic [15:0] v);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // noise, sync at any bit offset, 128 payload bits per beat
    task automatic send_window(input int n_beats, input bit cut, input bit with_first,
                               input bit retune);
        bit stream[$];
        logic [7:0] b;
        int nbytes;
        int mid;
        for (int j = 0; j < n_beats; j++) begin
            repeat ($urandom_range(0, 12))
                stream.insert(stream.size(), 1'($urandom_range(0, 1)));
            for (int i = 7; i >= 0; i--) stream.insert(stream.size(), SYNC_BYTE[i]);
            repeat (8 * BYTES_PER_BEAT)
                stream.insert(stream.size(), 1'($urandom_range(0, 1)));
        end
        if (cut && n_beats > 0)
            repeat ($urandom_range(1, 8 * BYTES_PER_BEAT - 1)) void'(stream.pop_back());
        else
            repeat ($urandom_range(0, 24))
                stream.insert(stream.size(), 1'($urandom_range(0, 1)));
        while (stream.size() == 0 || stream.size() % 8 != 0)
            stream.insert(stream.size(), 1'($urandom_range(0, 1)));
        nbytes = stream.size() / 8;
        mid = (retune && nbytes > 1) ? $urandom_range(1, nbytes - 1) : -1;
        for (int k = 0; k < nbytes; k++) begin
            if (k == mid)
                write_beats(16'($urandom_range(0, 3)));
            for (int i = 0; i < 8; i++) b[7 - i] = stream[8 * k + i];
            push_byte(b, with_first && k == 0, k == nbytes - 1);
        end
    endtask

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 20)) begin
            b = ($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom);
            push_byte(b, $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
        end
    endtask

    initial begin : stimulus
        logic [7:0]  fixed[8];
        logic [15:0] beats;
        int kind;
        int nb;
        fixed = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA};
        tx_gaps_on = 1'b0;
        rx_stall_on = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // bytes before any window start, reset register value of one beat
        push_byte(SYNC_BYTE, 1'b0, 1'b0);
        for (int i = 0; i < BYTES_PER_BEAT; i++)
            push_byte(i < 8 ? fixed[i] : 8'($urandom), 1'b0, i == BYTES_PER_BEAT - 1);
        // one-byte window: sync found, beat cut short
        push_byte(SYNC_BYTE, 1'b1, 1'b1);
        // zero beats expected, no window start after the last byte
        write_beats(16'd0);
        push_byte(8'h00, 1'b0, 1'b1);
        write_beats(16'hFFFF);
        push_byte(8'hA5, 1'b1, 1'b1);

        while (bytes_sent < 1920) begin
            kind = $urandom_range(0, 11);
            if (kind == 0)
                beats = 16'd0;
            else if (kind == 1)
                beats = 16'hFFFF;
            else
                beats = 16'($urandom_range(1, 4));
            write_beats(beats);
            tx_gaps_on = $urandom_range(0, 3) != 0;
            rx_stall_on = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(1, 3)) begin
                kind = $urandom_range(0, 9);
                nb = (beats > 4) ? $urandom_range(0, 2) : beats + $urandom_range(0, 1);
                if (kind <= 5)
                    send_window(nb, 1'b0, 1'b1, $urandom_range(0, 7) == 0);
                else if (kind == 6)
                    send_window(nb > 0 ? nb : 1, 1'b1, 1'b1, 1'b0);
                else if (kind == 7)
                    send_window(nb, 1'b0, 1'b0, 1'b0);
                else
                    send_noise();
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);
        if (deframer.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
